// ----- rtl/bam_broadcast_segmenter_unit_defines.svh -----
// Assertion macros for the verification of the broadcast segmenter.
// No dependencies; included by the checker bound to the top level.
`ifndef BAM_BROADCAST_SEGMENTER_UNIT_DEFINES_SVH
`define BAM_BROADCAST_SEGMENTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bbs_pkg.sv -----
// Package of the broadcast segmenter: command codes, states, frame constants
// and the store request structure. No dependencies.
`default_nettype none

package bbs_pkg;

  localparam int MESSAGE_BYTES_DEFAULT = 1785;
  localparam int PTR_W = 11;
  localparam int ELAPSED_W = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic REG_TICK_PERIOD = 1'b0;
  localparam logic [7:0] TICK_PERIOD_RESET = 8'd10;

  localparam logic [7:0] CTRL_BAM = 8'd32;
  localparam logic [7:0] PAD_BYTE = 8'hFF;
  localparam logic [7:0] BROADCAST = 8'hFF;
  localparam logic [2:0] BYTES_PER_PACKET = 3'd7;
  localparam logic [2:0] LAST_SLOT = 3'd6;
  localparam logic [ELAPSED_W-1:0] PACKET_GAP_MS = 16'd50;

  // Reciprocal of seven scaled by 2^16; exact for the length range in use.
  localparam logic [13:0] RECIP_SEVEN = 14'd9363;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [PTR_W-1:0] waddr;
    logic [PTR_W-1:0] raddr;
    logic [7:0]       wdata;
  } store_req_t;

endpackage

`default_nettype wire

// ----- rtl/bbs_store.sv -----
// Message byte store: one write port and one registered read port.
// Depends on bbs_pkg for the request structure.
`default_nettype none

module bbs_store #(
  parameter int DEPTH = bbs_pkg::MESSAGE_BYTES_DEFAULT
) (
  input  wire logic               clk,
  input  wire bbs_pkg::store_req_t req,
  output logic [7:0]              rdata
);
  import bbs_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[ADDR_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bbs_ctrl.sv -----
// Transfer sequencer: command decode, transfer counters, store reads and frame assembly.
// Depends on bbs_pkg; drives the request port of bbs_store.
`default_nettype none

module bbs_ctrl #(
  parameter int MESSAGE_BYTES = bbs_pkg::MESSAGE_BYTES_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [1:0]                cmd,
  input  wire logic [7:0]                data_byte,
  input  wire logic [bbs_pkg::PTR_W-1:0] message_length,
  input  wire logic [23:0]               group_number,
  input  wire logic [7:0]                destination,
  input  wire logic [7:0]                tick_period_ms,
  input  wire logic [7:0]                store_rdata,
  output bbs_pkg::store_req_t            store_req,
  output logic                           busy,
  output logic                           done,
  output logic                           frame_kind,
  output logic [7:0][7:0]                frame_bytes,
  output logic                           last_packet
);
  import bbs_pkg::*;

  localparam logic [PTR_W-1:0] DEPTH = PTR_W'(MESSAGE_BYTES);

  state_t state;
  state_t state_next;

  logic [PTR_W-1:0]     load_pointer;
  logic [PTR_W-1:0]     bytes_left;
  logic [PTR_W-1:0]     read_offset;
  logic [7:0]           next_sequence;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic                 sending;
  logic [2:0]           idx;
  logic [2:0]           take_n;
  logic                 cap_en;
  logic                 cap_take;
  logic [2:0]           cap_idx;

  logic                 accept;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 gap_reached;
  logic [PTR_W-1:0]     len_sat;
  logic [PTR_W:0]       len_round;
  logic [25:0]          count_prod;
  logic [2:0]           chunk;
  logic [PTR_W-1:0]     left_after;

  always_comb begin
    elapsed_sum = {1'b0, elapsed_ms} + {{(ELAPSED_W-7){1'b0}}, tick_period_ms};
    elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
    gap_reached = elapsed_sat >= PACKET_GAP_MS;
    len_sat     = (message_length > DEPTH) ? DEPTH : message_length;
    len_round   = {1'b0, len_sat} + (PTR_W+1)'(6);
    count_prod  = len_round * RECIP_SEVEN;
    chunk       = (bytes_left > PTR_W'(BYTES_PER_PACKET)) ? BYTES_PER_PACKET
                                                          : bytes_left[2:0];
    left_after  = bytes_left - {{(PTR_W-3){1'b0}}, take_n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    busy            = (state != ST_IDLE);
    accept          = start && (state == ST_IDLE);
    store_req.we    = 1'b0;
    store_req.re    = 1'b0;
    store_req.waddr = load_pointer;
    store_req.raddr = read_offset + {{(PTR_W-3){1'b0}}, idx};
    store_req.wdata = data_byte;
    unique case (state)
      ST_IDLE: begin
        store_req.we = accept && (cmd == CMD_LOAD) && (load_pointer < DEPTH);
        if (accept && (cmd == CMD_TICK) && sending && gap_reached) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        store_req.re = idx < take_n;
        if (idx == LAST_SLOT) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer  <= '0;
      bytes_left    <= '0;
      read_offset   <= '0;
      next_sequence <= 8'd1;
      elapsed_ms    <= '0;
      sending       <= 1'b0;
      done          <= 1'b0;
      cap_en        <= 1'b0;
    end else begin
      done     <= 1'b0;
      cap_en   <= (state == ST_READ);
      cap_idx  <= idx;
      cap_take <= idx < take_n;
      if (cap_en && cap_take) begin
        frame_bytes[cap_idx + 3'd1] <= store_rdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_LOAD: begin
                if (load_pointer < DEPTH) begin
                  load_pointer <= load_pointer + PTR_W'(1);
                end
              end
              CMD_START: begin
                if (destination == BROADCAST) begin
                  bytes_left     <= len_sat;
                  read_offset    <= '0;
                  next_sequence  <= 8'd1;
                  elapsed_ms     <= '0;
                  load_pointer   <= '0;
                  sending        <= (len_sat != '0);
                  done           <= 1'b1;
                  frame_kind     <= 1'b0;
                  last_packet    <= 1'b0;
                  frame_bytes[0] <= CTRL_BAM;
                  frame_bytes[1] <= len_sat[7:0];
                  frame_bytes[2] <= {5'b0, len_sat[PTR_W-1:8]};
                  frame_bytes[3] <= count_prod[23:16];
                  frame_bytes[4] <= PAD_BYTE;
                  frame_bytes[5] <= group_number[7:0];
                  frame_bytes[6] <= group_number[15:8];
                  frame_bytes[7] <= group_number[23:16];
                end
              end
              CMD_TICK: begin
                if (sending) begin
                  if (gap_reached) begin
                    elapsed_ms     <= '0;
                    idx            <= '0;
                    take_n         <= chunk;
                    frame_bytes[0] <= next_sequence;
                    for (int i = 1; i < 8; i++) begin
                      frame_bytes[i] <= PAD_BYTE;
                    end
                  end else begin
                    elapsed_ms <= elapsed_sat;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          idx <= idx + 3'd1;
        end
        ST_FINISH: begin
          read_offset   <= read_offset + {{(PTR_W-3){1'b0}}, take_n};
          bytes_left    <= left_after;
          next_sequence <= next_sequence + 8'd1;
          sending       <= (left_after != '0);
          done          <= 1'b1;
          frame_kind    <= 1'b1;
          last_packet   <= (left_after == '0);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bam_broadcast_segmenter_unit.sv -----
// A load gives no result; an announce appears on done in the cycle after its start
// transaction. A tick that releases a data frame holds busy through the read state (up to seven
// store reads on the single read port) and then the wrap-up state, and the frame appears on
// done in the cycle after the wrap-up state. Other ticks give no result.
// Reset is synchronous and active high; the message store is not cleared and needs loading.
// Results are strobed for one cycle on done; the receiver cannot stall.
// Top level of the broadcast segmenter: configuration register, sequencer and store.
// Depends on bbs_pkg, bbs_ctrl and bbs_store.
`default_nettype none

module bam_broadcast_segmenter_unit #(
  parameter int MESSAGE_BYTES = bbs_pkg::MESSAGE_BYTES_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                cmd,
  input  wire logic [7:0]                data_byte,
  input  wire logic [bbs_pkg::PTR_W-1:0] message_length,
  input  wire logic [23:0]               group_number,
  input  wire logic [7:0]                destination,
  output logic                           done,
  output logic                           frame_kind,
  output logic [7:0]                     frame_byte0,
  output logic [7:0]                     frame_byte1,
  output logic [7:0]                     frame_byte2,
  output logic [7:0]                     frame_byte3,
  output logic [7:0]                     frame_byte4,
  output logic [7:0]                     frame_byte5,
  output logic [7:0]                     frame_byte6,
  output logic [7:0]                     frame_byte7,
  output logic                           last_packet
);
  import bbs_pkg::*;

  logic [7:0]      tick_period_ms;
  store_req_t      store_req;
  logic [7:0]      store_rdata;
  logic [7:0][7:0] frame_bytes;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_TICK_PERIOD) ? {24'b0, tick_period_ms} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_ms <= TICK_PERIOD_RESET;
    end else if (cfg_write && (paddr[2] == REG_TICK_PERIOD)) begin
      tick_period_ms <= pwdata[7:0];
    end
  end

  bbs_ctrl #(
    .MESSAGE_BYTES(MESSAGE_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .message_length(message_length),
    .group_number  (group_number),
    .destination   (destination),
    .tick_period_ms(tick_period_ms),
    .store_rdata   (store_rdata),
    .store_req     (store_req),
    .busy          (busy),
    .done          (done),
    .frame_kind    (frame_kind),
    .frame_bytes   (frame_bytes),
    .last_packet   (last_packet)
  );

  bbs_store #(
    .DEPTH(MESSAGE_BYTES)
  ) u_store (
    .clk  (clk),
    .req  (store_req),
    .rdata(store_rdata)
  );

  assign frame_byte0 = frame_bytes[0];
  assign frame_byte1 = frame_bytes[1];
  assign frame_byte2 = frame_bytes[2];
  assign frame_byte3 = frame_bytes[3];
  assign frame_byte4 = frame_bytes[4];
  assign frame_byte5 = frame_bytes[5];
  assign frame_byte6 = frame_bytes[6];
  assign frame_byte7 = frame_bytes[7];

endmodule

`default_nettype wire

// ----- rtl/bbs_checker.sv -----
// Port-level checker for the broadcast segmenter and its bind to the top level.
// Depends on bbs_pkg and bam_broadcast_segmenter_unit_defines.svh.
`default_nettype none

`include "bam_broadcast_segmenter_unit_defines.svh"

module bbs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] cmd,
  input wire logic [7:0] destination,
  input wire logic       done,
  input wire logic       frame_kind,
  input wire logic [7:0] frame_byte0,
  input wire logic [7:0] frame_byte4,
  input wire logic       last_packet
);
  import bbs_pkg::*;

  logic take_load;
  logic take_bcast;
  logic take_other;
  logic announce_out;
  logic announce_ok;

  assign take_load    = start && !busy && (cmd == CMD_LOAD);
  assign take_bcast   = start && !busy && (cmd == CMD_START) && (destination == BROADCAST);
  assign take_other   = start && !busy && (cmd == CMD_START) && (destination != BROADCAST);
  assign announce_out = done && !frame_kind;
  assign announce_ok  = announce_out && (frame_byte0 == CTRL_BAM) && (frame_byte4 == PAD_BYTE);

  `BBS_ASSERT_NEXT(a_load_silent, clk, rst, take_load, !done, "load produced a result")
  `BBS_ASSERT_NEXT(a_announce, clk, rst, take_bcast, announce_ok, "announce missing or malformed")
  `BBS_ASSERT_NEXT(a_unicast_silent, clk, rst, take_other, !done, "unicast start gave a result")
  `BBS_ASSERT_NOW(a_announce_not_last, clk, rst, announce_out, !last_packet, "announce marked last")

endmodule

bind bam_broadcast_segmenter_unit bbs_checker u_bbs_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .destination(destination),
  .done       (done),
  .frame_kind (frame_kind),
  .frame_byte0(frame_byte0),
  .frame_byte4(frame_byte4),
  .last_packet(last_packet)
);

`default_nettype wire
